[design/assert_macros.svh]
// assertion macros shared by the management frame master
// no dependencies; clock and reset are passed in by the user
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition in this cycle implies property in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error(msg);

// condition in this cycle implies property in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error(msg);

`endif

[design/mdio_pkg.sv]
// package for the management frame master: codes, frame constants and types
// used by every module of the block; no dependencies
`default_nettype none

package mdio_pkg;

    // frame lengths
    localparam int WRITE_PREAMBLE_BITS = 64;
    localparam int READ_PREAMBLE_BITS  = 32;
    localparam int TAIL_BITS           = 32;
    localparam int HEADER_BITS         = 14;
    localparam int DATA_BITS           = 16;
    localparam int MAX_PREAMBLE_BITS   = (WRITE_PREAMBLE_BITS > READ_PREAMBLE_BITS) ?
                                         WRITE_PREAMBLE_BITS : READ_PREAMBLE_BITS;
    localparam int BIT_IDX_W           = $clog2(MAX_PREAMBLE_BITS + TAIL_BITS);

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;
    localparam int PORT_W     = 3;
    localparam int REG_W      = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_PORT_ADDR = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_ADDR  = 4'd1;

    // frame field codes
    localparam logic [1:0] FRAME_START = 2'b01;
    localparam logic [1:0] OP_WRITE    = 2'b01;
    localparam logic [1:0] OP_READ     = 2'b10;
    localparam logic [1:0] TA_WRITE    = 2'b10;
    localparam logic [1:0] TA_RELEASED = 2'b00;
    localparam logic [1:0] ADDR_PAD    = 2'b00;

    // stream widths
    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_TICK  = 2'd2
    } t_kind;

    typedef logic [BIT_IDX_W-1:0] t_bit_idx;

    typedef struct packed {
        logic [PORT_W-1:0] port_addr;
        logic [REG_W-1:0]  reg_addr;
    } t_cfg;

    // mdc sits in the lowest bit
    typedef struct packed {
        logic [DATA_BITS-1:0] read_data;
        logic                 done;
        logic                 busy;
        logic                 drive;
        logic                 line_out;
        logic                 mdc;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

`default_nettype wire

[design/mdio_cfg_regs.sv]
// configuration registers of the management frame master (port and register number)
// depends on mdio_pkg
`default_nettype none

module mdio_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [mdio_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [mdio_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output mdio_pkg::t_cfg                        o_cfg
);

    mdio_pkg::t_cfg r_cfg;
    mdio_pkg::t_cfg n_cfg;

    // writes always taken at once
    assign o_cfg_ready = 1'b1;

    // decode of the register index; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            if (i_cfg_index == mdio_pkg::CFG_PORT_ADDR) begin
                n_cfg.port_addr = i_cfg_data[mdio_pkg::PORT_W-1:0];
            end else if (i_cfg_index == mdio_pkg::CFG_REG_ADDR) begin
                n_cfg.reg_addr = i_cfg_data[mdio_pkg::REG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[design/mdio_frame_seq.sv]
// frame sequencer: frame state, next-state logic and line levels for one transfer
// depends on mdio_pkg
`default_nettype none

module mdio_frame_seq (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_accept,
    input  wire logic [1:0]                      i_kind,
    input  wire logic [mdio_pkg::DATA_BITS-1:0]  i_write_data,
    input  wire logic                            i_mdio_in,
    input  wire mdio_pkg::t_cfg                  i_cfg,
    output mdio_pkg::t_result                    o_result
);

    logic                                 r_active,      n_active;
    logic                                 r_is_write,    n_is_write;
    mdio_pkg::t_bit_idx                   r_bit_idx,     n_bit_idx;
    logic                                 r_phase,       n_phase;
    logic [mdio_pkg::DATA_BITS-1:0]       r_send,        n_send;
    logic [mdio_pkg::DATA_BITS-1:0]       r_recv,        n_recv;
    logic [mdio_pkg::HEADER_BITS-1:0]     r_header,      n_header;
    logic [mdio_pkg::DATA_BITS-1:0]       r_read_result, n_read_result;
    logic                                 done;

    mdio_pkg::t_bit_idx                   cur_pre;
    mdio_pkg::t_bit_idx                   next_pre;
    mdio_pkg::t_bit_idx                   tail_pos;
    logic [mdio_pkg::TAIL_BITS-1:0]       tail_word;
    logic                                 in_preamble;
    logic                                 drive;
    logic                                 level;

    // preamble length of the frame in progress
    assign cur_pre = r_is_write ? mdio_pkg::t_bit_idx'(mdio_pkg::WRITE_PREAMBLE_BITS)
                                : mdio_pkg::t_bit_idx'(mdio_pkg::READ_PREAMBLE_BITS);

    // next state for one accepted transfer
    always_comb begin
        n_active      = r_active;
        n_is_write    = r_is_write;
        n_bit_idx     = r_bit_idx;
        n_phase       = r_phase;
        n_send        = r_send;
        n_recv        = r_recv;
        n_header      = r_header;
        n_read_result = r_read_result;
        done          = 1'b0;
        if (i_accept) begin
            unique case (i_kind)
                mdio_pkg::KIND_READ, mdio_pkg::KIND_WRITE: begin
                    // commands while a frame runs are ignored
                    if (!r_active) begin
                        n_active   = 1'b1;
                        n_is_write = (i_kind == mdio_pkg::KIND_WRITE);
                        n_bit_idx  = '0;
                        n_phase    = 1'b0;
                        n_header   = {mdio_pkg::FRAME_START,
                                      (i_kind == mdio_pkg::KIND_WRITE) ?
                                          mdio_pkg::OP_WRITE : mdio_pkg::OP_READ,
                                      mdio_pkg::ADDR_PAD, i_cfg.port_addr, i_cfg.reg_addr};
                        if (i_kind == mdio_pkg::KIND_WRITE) begin
                            n_send = i_write_data;
                        end else begin
                            n_recv = '0;
                        end
                    end
                end
                mdio_pkg::KIND_TICK: begin
                    if (r_active) begin
                        if (!r_phase) begin
                            // rising mdc: sample read data bits
                            n_phase = 1'b1;
                            if (!r_is_write && (r_bit_idx >= cur_pre +
                                    mdio_pkg::t_bit_idx'(mdio_pkg::DATA_BITS))) begin
                                n_recv = {r_recv[mdio_pkg::DATA_BITS-2:0], i_mdio_in};
                            end
                            // last bit of the frame
                            if (r_bit_idx == cur_pre +
                                    mdio_pkg::t_bit_idx'(mdio_pkg::TAIL_BITS - 1)) begin
                                n_active  = 1'b0;
                                n_bit_idx = '0;
                                done      = 1'b1;
                                if (!r_is_write) begin
                                    n_read_result = n_recv;
                                end
                            end
                        end else begin
                            // falling mdc: move to the next bit
                            n_phase   = 1'b0;
                            n_bit_idx = r_bit_idx + mdio_pkg::t_bit_idx'(1);
                        end
                    end
                end
                default: begin
                    // unused kind code: no change
                end
            endcase
        end
    end

    // line levels seen after the update
    assign next_pre = n_is_write ? mdio_pkg::t_bit_idx'(mdio_pkg::WRITE_PREAMBLE_BITS)
                                 : mdio_pkg::t_bit_idx'(mdio_pkg::READ_PREAMBLE_BITS);
    assign in_preamble = (n_bit_idx < next_pre);
    assign tail_pos    = n_bit_idx - next_pre;
    assign tail_word   = {n_header,
                          n_is_write ? mdio_pkg::TA_WRITE : mdio_pkg::TA_RELEASED,
                          n_is_write ? n_send : {mdio_pkg::DATA_BITS{1'b0}}};

    always_comb begin
        drive = n_active && (n_is_write || in_preamble ||
                (tail_pos < mdio_pkg::t_bit_idx'(mdio_pkg::HEADER_BITS)));
        level = 1'b0;
        if (drive) begin
            level = in_preamble ? 1'b1 : tail_word[5'd31 - tail_pos[4:0]];
        end
    end

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_is_write    <= 1'b0;
            r_bit_idx     <= '0;
            r_phase       <= 1'b0;
            r_read_result <= '0;
        end else begin
            r_active      <= n_active;
            r_is_write    <= n_is_write;
            r_bit_idx     <= n_bit_idx;
            r_phase       <= n_phase;
            r_read_result <= n_read_result;
        end
    end

    // shift and header payload, loaded when a frame starts
    always_ff @(posedge i_clk) begin
        r_send   <= n_send;
        r_recv   <= n_recv;
        r_header <= n_header;
    end

    always_comb begin
        o_result.read_data = n_read_result;
        o_result.done      = done;
        o_result.busy      = n_active;
        o_result.drive     = drive;
        o_result.line_out  = level;
        o_result.mdc       = n_phase;
    end

endmodule

`default_nettype wire

[design/mdio_out_reg.sv]
// result register with stream handshake towards the master side
// depends on mdio_pkg
`default_nettype none

module mdio_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire mdio_pkg::t_result i_result,
    input  wire logic              i_m_tready,
    output logic                   o_m_tvalid,
    output mdio_pkg::t_result      o_result,
    output logic                   o_space
);

    logic              r_valid;
    logic              n_valid;
    mdio_pkg::t_result r_result;

    // free when empty or the held result leaves this cycle
    assign o_space = !r_valid || i_m_tready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_m_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_result   = r_result;

endmodule

`default_nettype wire

[design/mdio_management_frame_master.sv]
// top level of the management frame master: config registers, sequencer, result register
// depends on mdio_pkg, mdio_cfg_regs, mdio_frame_seq, mdio_out_reg, assert_macros.svh
//
//  channel   direction  handshake               payload
//  s stream  in         i_s_tvalid/o_s_tready   tuser kind, tdata write_data, mdio_in
//  m stream  out        o_m_tvalid/i_m_tready   tdata mdc .. read_data
//  cfg       in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// one item per cycle while the result register has space; its result sits in the output register on the next cycle
// the frame state is updated in a single pass between the state and result registers
// reset clears config, frame state and read data; mdc starts low, no clearing pass
// the input stalls only while the result register holds an untaken result
`default_nettype none
`include "assert_macros.svh"

module mdio_management_frame_master (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // slave stream
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // tdata: write_data[15:0], mdio_in[16], zero[23:17]
    input  wire logic [mdio_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // tuser: kind[1:0]
    input  wire logic [mdio_pkg::IN_TUSER_W-1:0]    i_s_tuser,
    // master stream
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // tdata: mdc[0], line_out[1], mdio_drive[2], busy_res[3], done_res[4],
    //        read_data[20:5], zero[23:21]
    output logic [mdio_pkg::OUT_TDATA_W-1:0]        o_m_tdata,
    // configuration writes
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [mdio_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [mdio_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    mdio_pkg::t_cfg    cfg;
    mdio_pkg::t_result seq_result;
    mdio_pkg::t_result out_result;
    logic              space;
    logic              in_xfer;

    assign o_s_tready = space;
    assign in_xfer    = i_s_tvalid && space;

    mdio_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mdio_frame_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_xfer),
        .i_kind       (i_s_tuser),
        .i_write_data (i_s_tdata[mdio_pkg::DATA_BITS-1:0]),
        .i_mdio_in    (i_s_tdata[mdio_pkg::DATA_BITS]),
        .i_cfg        (cfg),
        .o_result     (seq_result)
    );

    mdio_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_xfer),
        .i_result   (seq_result),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_result   (out_result),
        .o_space    (space)
    );

    // result packed from mdc upwards, padded to whole bytes
    assign o_m_tdata = {{(mdio_pkg::OUT_TDATA_W - mdio_pkg::RESULT_W){1'b0}}, out_result};

    // a held result blocks the input
    `ASSERT_SAME(a_stall_blocks_input, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, !o_s_tready, "input accepted while result register full")
    // every accepted item leaves a result
    `ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n, i_s_tvalid && o_s_tready, o_m_tvalid, "accepted transfer produced no result")
    // a finishing tick leaves the master idle
    `ASSERT_SAME(a_done_not_busy, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[4], !o_m_tdata[3], "done reported with frame still busy")
    // the line is only driven inside a frame
    `ASSERT_SAME(a_drive_in_frame, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[2], o_m_tdata[3], "data line driven while idle")

endmodule

`default_nettype wire

[tb/tb_mdio_management_frame_master.sv]
// testbench for the management frame master: command and tick transfers in, line states out
// every line state is predicted from the frame sequence and checked by a scoreboard class
// depends on mdio_pkg and the design top level mdio_management_frame_master
module tb_mdio_management_frame_master;
    timeunit 1ns;
    timeprecision 1ps;

    // kind code that the block treats as an idle item
    localparam logic [1:0] KIND_IDLE = 2'd3;
    localparam int FRAME_ITEMS = 1700;

    // frame sequence predictor and store of expected line states
    class frame_scoreboard;
        logic [mdio_pkg::PORT_W-1:0]      port_addr = '0;
        logic [mdio_pkg::REG_W-1:0]       reg_addr = '0;
        bit                               active = 0;
        bit                               is_write = 0;
        bit                               phase = 0;
        mdio_pkg::t_bit_idx               bit_idx = '0;
        logic [mdio_pkg::DATA_BITS-1:0]   send_word = '0;
        logic [mdio_pkg::DATA_BITS-1:0]   recv_word = '0;
        logic [mdio_pkg::DATA_BITS-1:0]   last_read = '0;
        logic [mdio_pkg::HEADER_BITS-1:0] header = '0;
        mdio_pkg::t_result                expected_lines[$];
        int                               errors = 0;

        // advance the frame by one accepted item and queue the line state it leaves
        function void note_item(logic [1:0] kind, logic [mdio_pkg::DATA_BITS-1:0] wdata,
                                logic mdio_in);
            mdio_pkg::t_result              line;
            logic [mdio_pkg::TAIL_BITS-1:0] tail;
            int                             pre;
            int                             total;
            int                             pos;
            bit                             done;
            done = 0;
            if ((kind == mdio_pkg::KIND_READ || kind == mdio_pkg::KIND_WRITE) && !active) begin
                // header is latched from the registers as the frame starts
                active = 1;
                is_write = (kind == mdio_pkg::KIND_WRITE);
                bit_idx = '0;
                phase = 0;
                header = {mdio_pkg::FRAME_START,
                          is_write ? mdio_pkg::OP_WRITE : mdio_pkg::OP_READ,
                          mdio_pkg::ADDR_PAD, port_addr, reg_addr};
                if (is_write)
                    send_word = wdata;
                else
                    recv_word = '0;
            end else if (kind == mdio_pkg::KIND_TICK && active) begin
                pre = is_write ? mdio_pkg::WRITE_PREAMBLE_BITS : mdio_pkg::READ_PREAMBLE_BITS;
                total = pre + mdio_pkg::TAIL_BITS;
                pos = int'(bit_idx);
                if (!phase) begin
                    // rising half: sample read data, maybe finish the frame
                    phase = 1;
                    if (!is_write && pos >= pre + mdio_pkg::TAIL_BITS - mdio_pkg::DATA_BITS &&
                        pos < total)
                        recv_word = {recv_word[mdio_pkg::DATA_BITS-2:0], mdio_in};
                    if (pos + 1 >= total) begin
                        active = 0;
                        bit_idx = '0;
                        done = 1;
                        if (!is_write)
                            last_read = recv_word;
                    end
                end else begin
                    phase = 0;
                    bit_idx = bit_idx + mdio_pkg::t_bit_idx'(1);
                end
            end

            // data line as presented for the current bit
            pre = is_write ? mdio_pkg::WRITE_PREAMBLE_BITS : mdio_pkg::READ_PREAMBLE_BITS;
            pos = int'(bit_idx);
            line = '0;
            if (active && (is_write || pos < pre || (pos - pre) < mdio_pkg::HEADER_BITS)) begin
                line.drive = 1'b1;
                tail = {header, is_write ? mdio_pkg::TA_WRITE : mdio_pkg::TA_RELEASED,
                        is_write ? send_word : {mdio_pkg::DATA_BITS{1'b0}}};
                if (pos < pre)
                    line.line_out = 1'b1;
                else
                    line.line_out = tail[mdio_pkg::TAIL_BITS - 1 -
                                         ((pos - pre) & (mdio_pkg::TAIL_BITS - 1))];
            end
            line.mdc = phase;
            line.busy = active;
            line.done = done;
            line.read_data = last_read;
            expected_lines.push_back(line);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $error("%s: expected %0h, got %0h", name, want, got);
            end
        endfunction

        // compare one result transfer against the oldest expectation
        function void check_line_state(logic [mdio_pkg::OUT_TDATA_W-1:0] tdata);
            mdio_pkg::t_result got;
            mdio_pkg::t_result want;
            got = tdata[mdio_pkg::RESULT_W-1:0];
            if (expected_lines.size() == 0) begin
                errors++;
                $error("result transfer with nothing expected, tdata %h", tdata);
            end else begin
                want = expected_lines.pop_front();
                compare_field("mdc", 32'(want.mdc), 32'(got.mdc));
                compare_field("line_out", 32'(want.line_out), 32'(got.line_out));
                compare_field("mdio_drive", 32'(want.drive), 32'(got.drive));
                compare_field("busy_res", 32'(want.busy), 32'(got.busy));
                compare_field("done_res", 32'(want.done), 32'(got.done));
                compare_field("read_data", 32'(want.read_data), 32'(got.read_data));
                compare_field("tdata padding", '0,
                              32'(tdata[mdio_pkg::OUT_TDATA_W-1:mdio_pkg::RESULT_W]));
            end
        endfunction
    endclass

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_tvalid = 1'b0;
    logic                             o_s_tready;
    logic [mdio_pkg::IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic [mdio_pkg::IN_TUSER_W-1:0]  i_s_tuser = '0;
    logic                             o_m_tvalid;
    logic                             i_m_tready = 1'b0;
    logic [mdio_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [mdio_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [mdio_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    frame_scoreboard sb;
    bit              quiet = 0;
    int              stall_left = 0;

    mdio_management_frame_master dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // config value with random upper bits and, now and then, extreme low bits
    function automatic logic [mdio_pkg::CFG_DATA_W-1:0] cfg_value(
            logic [mdio_pkg::CFG_DATA_W-1:0] mask);
        logic [mdio_pkg::CFG_DATA_W-1:0] v;
        int                              r;
        v = mdio_pkg::CFG_DATA_W'($urandom);
        r = $urandom_range(0, 3);
        if (r == 0)
            v = v & ~mask;
        else if (r == 1)
            v = v | mask;
        return v;
    endfunction

    // receiver stalls
    always @(posedge i_clk) begin
        if (quiet) begin
            i_m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_m_tready <= 1'b1;
            stall_left <= pause_len();
        end
    end

    // result transfers go to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_line_state(o_m_tdata);
    end

    // one input transfer, preceded by a random gap
    task automatic send_item(logic [1:0] kind, logic [mdio_pkg::DATA_BITS-1:0] wdata,
                             logic mdio_in);
        int gap;
        gap = pause_len();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= kind;
        i_s_tdata <= {{(mdio_pkg::IN_TDATA_W - mdio_pkg::DATA_BITS - 1){1'b0}}, mdio_in, wdata};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_item(kind, wdata, mdio_in);
    endtask

    // hold the sender until every expected line state has come
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (sb.expected_lines.size() != 0) @(posedge i_clk);
    endtask

    // register writes; sel bit 0 port address, bit 1 register address
    task automatic load_config(logic [1:0] sel, logic [mdio_pkg::CFG_DATA_W-1:0] port_val,
                               logic [mdio_pkg::CFG_DATA_W-1:0] reg_val);
        for (int i = 0; i < 2; i++) begin
            if (sel[i]) begin
                i_cfg_valid <= 1'b1;
                i_cfg_index <= (i == 0) ? mdio_pkg::CFG_PORT_ADDR : mdio_pkg::CFG_REG_ADDR;
                i_cfg_data <= (i == 0) ? port_val : reg_val;
                do @(posedge i_clk); while (!o_cfg_ready);
                if (i == 0)
                    sb.port_addr = port_val[mdio_pkg::PORT_W-1:0];
                else
                    sb.reg_addr = reg_val[mdio_pkg::REG_W-1:0];
            end
        end
        i_cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial begin
        int                             sent;
        int                             ticks;
        int                             change_at;
        int                             n;
        logic [mdio_pkg::DATA_BITS-1:0] wdata;
        sb = new();
        sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extreme header, idle items, commands while busy
        load_config(2'b11, 8'hFF, 8'hFF);
        send_item(mdio_pkg::KIND_TICK, 16'h0000, 1'b1);
        send_item(KIND_IDLE, 16'hFFFF, 1'b1);
        send_item(mdio_pkg::KIND_WRITE, 16'hFFFF, 1'b0);
        send_item(mdio_pkg::KIND_READ, 16'h0000, 1'b1);
        send_item(mdio_pkg::KIND_WRITE, 16'h0000, 1'b0);
        send_item(KIND_IDLE, 16'h5A5A, 1'b0);
        repeat (3) send_item(mdio_pkg::KIND_TICK, 16'hFFFF, 1'b1);
        // registers changed mid-frame must not touch the latched header
        settle();
        load_config(2'b11, 8'h00, 8'h00);
        repeat (4) send_item(mdio_pkg::KIND_TICK, 16'h0000, 1'b0);

        // random frames with noise; the directed frame finishes first
        while (sent < FRAME_ITEMS) begin
            quiet = ($urandom_range(0, 3) == 0);
            if (!sb.active) begin
                if ($urandom_range(0, 1)) begin
                    settle();
                    load_config(2'($urandom_range(1, 3)), cfg_value(8'h07), cfg_value(8'h1F));
                end
                // ticks while idle leave mdc where it is
                repeat ($urandom_range(0, 2))
                    send_item(mdio_pkg::KIND_TICK, 16'($urandom), 1'($urandom));
                n = $urandom_range(0, 9);
                wdata = (n == 0) ? 16'h0000 : (n == 1) ? 16'hFFFF : 16'($urandom);
                send_item($urandom_range(0, 1) ? mdio_pkg::KIND_WRITE : mdio_pkg::KIND_READ,
                          wdata, 1'($urandom));
                sent++;
            end
            change_at = $urandom_range(1, 400);
            ticks = 0;
            while (sb.active) begin
                if ($urandom_range(0, 99) < 6) begin
                    n = $urandom_range(0, 2);
                    send_item((n == 0) ? KIND_IDLE :
                              (n == 1) ? mdio_pkg::KIND_READ : mdio_pkg::KIND_WRITE,
                              16'($urandom), 1'($urandom));
                end else begin
                    send_item(mdio_pkg::KIND_TICK, 16'($urandom), 1'($urandom));
                    sent++;
                    ticks++;
                    if (ticks == change_at) begin
                        settle();
                        load_config(2'($urandom_range(1, 3)), cfg_value(8'h07),
                                    cfg_value(8'h1F));
                    end
                end
            end
        end

        // drain and finish
        settle();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_lines.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end
endmodule
